// ===== src/tcwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwm_pkg
// Shared types and constants of the time cluster weighted merge core.
// ----------------------------------------------------------------------------
package tcwm_pkg;
  localparam int TIME_W = 32;
  localparam int VAR_W  = 48;
  localparam int IDX_W  = 16;
  localparam int THR_W  = 16;

  localparam logic [VAR_W-1:0] MARGIN_RESET = 48'd4294967296;
  localparam logic [THR_W-1:0] THRESH_RESET = 16'd6400;
  localparam logic [VAR_W-1:0] VAR_MAX      = {VAR_W{1'b1}};

  localparam logic [0:0] REG_MARGIN = 1'b0;
  localparam logic [0:0] REG_THRESH = 1'b1;

  // quotient and denominator width of the shared divider
  localparam int DIV_Q_W = 64;
  localparam int DIV_D_W = 52;

  typedef struct packed {
    logic load;
    logic gate;
    logic start_off;
    logic start_var;
    logic commit;
    logic emit_old;
    logic emit_cur;
    logic emit_last;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic open;
    logic compat;
    logic sum_zero;
    logic div_busy;
    logic eos;
  } dp_sts_t;
endpackage

// ===== src/time_cluster_weighted_merge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_cluster_weighted_merge_core
// A closed cluster is offered after its closing item passes the gate compare;
// the final one of a stream after the end-of-stream item is committed.
// One item at a time: a merge with a nonzero variance sum takes two passes of
// the shared multiply-divide unit, end of stream adds a final emit; a stalled
// output holds the sequencer. rst clears cluster state and counter and resets the registers.
// ----------------------------------------------------------------------------
module time_cluster_weighted_merge_core import tcwm_pkg::*; #(
  parameter int MAX_ITEMS = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // track_time, track_sigma
  input  logic         s_tlast,   // end_of_stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // cluster_time, cluster_variance, first, last
  output logic         m_tlast,   // last_of_run
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [47:0]  cfg_data
);
  localparam int CNT_W = $clog2(MAX_ITEMS);
  localparam logic [CNT_W-1:0] MAX_M1 = CNT_W'(MAX_ITEMS - 1);

  logic [VAR_W-1:0] margin;
  logic [THR_W-1:0] thresh;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic idle, in_fire;
  logic [127:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET; thresh <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARGIN: margin <= cfg_data;
        REG_THRESH: thresh <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = idle;
  assign in_fire  = s_tvalid & s_tready;

  tcwm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
    .sts(sts), .cmd(cmd), .idle(idle)
  );

  tcwm_datapath #(.CNT_W(CNT_W)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_time(s_tdata[31:0]), .in_sigma(s_tdata[63:32]), .in_eos(s_tlast),
    .margin(margin), .thresh(thresh), .max_m1(MAX_M1), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.emit_old || cmd.emit_cur) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = res[111:0];
  assign m_tlast = res[112];
endmodule

// ===== src/tcwm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwm_div
// Multiply-divide unit: n = a * b in three 16-bit digit steps, then a radix-2
// restoring divide q = (2n + d) / (2d), nearest, halves up, eight quotient
// bits per cycle. Busy from start through the multiply, form and divide steps.
// ----------------------------------------------------------------------------
module tcwm_div import tcwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VAR_W-1:0]   fac_a,
  input  logic [VAR_W-1:0]   fac_b,
  input  logic [DIV_D_W-1:0] denom,
  output logic               busy,
  output logic [DIV_Q_W-1:0] quot
);
  localparam int STEPS     = 8;
  localparam int ITERS     = 128 / STEPS;
  localparam int DIGIT_W   = 16;
  localparam int MUL_STEPS = VAR_W / DIGIT_W;
  localparam int PROD_W    = 2 * VAR_W;
  localparam logic [4:0] CNT_START = 5'(MUL_STEPS + 1 + ITERS);
  localparam logic [4:0] CNT_FORM  = 5'(ITERS + 1);

  logic [VAR_W-1:0]         fa, fb;
  logic [PROD_W-1:0]        acc;
  logic [VAR_W+DIGIT_W-1:0] digit_prod;
  logic [127:0]             sh;
  logic [DIV_D_W:0]         dd;
  logic [DIV_D_W+1:0]       rem;
  logic [4:0]               cnt;
  logic [127:0]             sh_next;
  logic [DIV_D_W+1:0]       rem_next;
  logic [DIV_Q_W-1:0]       quot_next;
  logic [DIV_D_W+1:0]       r;

  assign digit_prod = {{DIGIT_W{1'b0}}, fa} * {{VAR_W{1'b0}}, fb[VAR_W-1 -: DIGIT_W]};

  always_comb begin
    sh_next   = sh;
    rem_next  = rem;
    quot_next = quot;
    for (int i = 0; i < STEPS; i++) begin
      r = {rem_next[DIV_D_W:0], sh_next[127]};
      sh_next = {sh_next[126:0], 1'b0};
      quot_next = {quot_next[DIV_Q_W-2:0], 1'b0};
      if (r >= {1'b0, dd}) begin
        r = r - {1'b0, dd};
        quot_next[0] = 1'b1;
      end
      rem_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_START;
    end else if (cnt != '0) begin
      cnt <= cnt - 5'd1;
    end
    if (start) begin
      fa  <= fac_a;
      fb  <= fac_b;
      acc <= '0;
      dd  <= {denom, 1'b0};
    end else if (cnt > CNT_FORM) begin
      acc <= {acc[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(digit_prod);
      fb  <= {fb[VAR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end else if (cnt == CNT_FORM) begin
      sh   <= {{(127-PROD_W){1'b0}}, acc, 1'b0} +
              {{(128-DIV_D_W){1'b0}}, dd[DIV_D_W:1]};
      rem  <= '0;
      quot <= '0;
    end else if (cnt != '0) begin
      sh   <= sh_next;
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

  assign busy = (cnt != '0);
endmodule

// ===== src/tcwm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwm_datapath
// Cluster state, gate compare, merge arithmetic and result register.
// ----------------------------------------------------------------------------
module tcwm_datapath import tcwm_pkg::*; #(
  parameter int CNT_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [TIME_W-1:0]   in_time,
  input  logic [TIME_W-1:0]   in_sigma,
  input  logic                in_eos,
  input  logic [VAR_W-1:0]    margin,
  input  logic [THR_W-1:0]    thresh,
  input  logic [CNT_W-1:0]    max_m1,
  output logic [127:0]        res
);
  logic signed [TIME_W-1:0] t_r, mean;
  logic [VAR_W-1:0]         tv, cvar;
  logic [IDX_W-1:0]         first, last;
  logic [CNT_W-1:0]         cnt, idx;
  logic                     open, eos, compat, neg;
  logic [VAR_W-1:0]         off_r;
  logic [VAR_W+1:0]         err;
  logic [63:0]              sq;
  logic [32:0]              mag;
  logic [72:0]              lhs, rhs;
  logic [VAR_W:0]           sum;
  logic                     dstart, dbusy;
  logic [VAR_W-1:0]         dfac_b;
  logic [DIV_Q_W-1:0]       dq;
  logic [63:0]              tv_full;
  logic signed [TIME_W:0]   diff;

  assign tv_full = 64'(in_sigma) * 64'(in_sigma);
  assign diff    = 33'(mean) - 33'(t_r);
  assign mag     = diff[TIME_W] ? 33'(-diff) : 33'(diff);
  assign err     = 50'(tv) + 50'(cvar) + 50'(margin);
  assign sum     = 49'(cvar) + 49'(tv);

  always_ff @(posedge clk) begin
    sq  <= 64'(mag[31:0]) * 64'(mag[31:0]) + (mag[32] ? 64'h0 : 64'h0);
    lhs <= {1'b0, mag[32] ? 64'hFFFF_FFFF_FFFF_FFFF : sq, 8'd0};
    rhs <= 73'(err) * 73'(thresh);
  end

  assign dstart = cmd.start_off | cmd.start_var;
  assign dfac_b = cmd.start_off ? VAR_W'(mag) : tv;

  tcwm_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .fac_a(cvar), .fac_b(dfac_b),
    .denom(DIV_D_W'(sum)), .busy(dbusy), .quot(dq)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      open <= 1'b0; mean <= '0; cvar <= '0; first <= '0; last <= '0;
      cnt <= '0;
    end else begin
      if (cmd.load) begin
        t_r <= in_time;
        tv  <= (tv_full[63:VAR_W] != '0) ? VAR_MAX : tv_full[VAR_W-1:0];
        eos <= in_eos;
        idx <= cnt;
        cnt <= (cnt == max_m1) ? '0 : cnt + 1'b1;
        neg <= 1'b0;
      end
      if (cmd.gate) begin
        compat <= open && (lhs < rhs);
        neg    <= t_r < mean;
      end
      if (cmd.start_var) off_r <= dq[VAR_W-1:0];
      if (cmd.commit) begin
        if (!open || !compat) begin
          open <= 1'b1; mean <= t_r; cvar <= tv;
          first <= IDX_W'(idx); last <= IDX_W'(idx);
        end else begin
          if (sum == '0) begin
            cvar <= '0;
          end else begin
            mean <= neg ? mean - TIME_W'(off_r) : mean + TIME_W'(off_r);
            cvar <= dq[VAR_W-1:0];
          end
          last <= IDX_W'(idx);
        end
      end
    end
  end
  // reset of cnt also on clear (end of stream)
  always_ff @(posedge clk) begin
    if (cmd.emit_old || cmd.emit_cur) begin
      res <= {15'd0, cmd.emit_last, last, first, cvar, mean};
    end
  end

  assign sts.open     = open;
  assign sts.compat   = compat;
  assign sts.sum_zero = (sum == '0);
  assign sts.div_busy = dbusy;
  assign sts.eos      = eos;
endmodule

// ===== src/tcwm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwm_ctrl
// Sequencer: load, gate, divides, commit, result hand-off.
// ----------------------------------------------------------------------------
module tcwm_ctrl import tcwm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    idle
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_MUL  = 10'b0000000010, S_GATE = 10'b0000000100,
    S_EMIT = 10'b0000001000, S_OFF  = 10'b0000010000, S_OFFW = 10'b0000100000,
    S_VARW = 10'b0001000000, S_COMM = 10'b0010000000, S_FIN  = 10'b0100000000,
    S_MUL2 = 10'b1000000000
  } state_t;
  state_t state, state_next;
  logic started;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
    if (state == S_OFF) started <= 1'b1;
    else if (state == S_OFFW && !sts.div_busy) started <= 1'b0;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_next = S_MUL; end
      S_MUL:  state_next = S_MUL2;
      S_MUL2: state_next = S_GATE;
      S_GATE: begin cmd.gate = 1'b1; state_next = S_EMIT; end
      S_EMIT: if (sts.open && !sts.compat) begin
          if (!out_busy) begin
            cmd.emit_old = 1'b1; cmd.emit_last = !sts.eos; state_next = S_COMM;
          end
        end else if (sts.open && !sts.sum_zero) begin
          state_next = S_OFF;
        end else begin
          state_next = S_COMM;
        end
      S_OFF:  begin cmd.start_off = 1'b1; state_next = S_OFFW; end
      S_OFFW: if (!sts.div_busy && started) begin
          cmd.start_var = 1'b1; state_next = S_VARW;
        end
      S_VARW: if (!sts.div_busy) state_next = S_COMM;
      S_COMM: begin cmd.commit = 1'b1; state_next = sts.eos ? S_FIN : S_IDLE; end
      S_FIN:  if (!out_busy) begin
          cmd.emit_cur = 1'b1; cmd.emit_last = 1'b1; cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_noemit2: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_old && cmd.emit_cur)) else $error("double emit");
  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_MUL) else $error("load sequence");
endmodule
